// ===== design/jsu_pkg.sv =====
// Package for the JSON string unescape unit: parse modes, result kinds,
// error codes, stream widths and the hex digit decoder.
// Used by jsu_step, json_string_unescape_unit and jsu_checker.
package jsu_pkg;

	localparam int unsigned CpW      = 21;
	localparam int unsigned ErrW     = 4;
	localparam int unsigned KindW    = 2;
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 32;

	typedef enum logic [6:0] {
		MODE_IDLE = 7'b0000001,
		MODE_BODY = 7'b0000010,
		MODE_ESC  = 7'b0000100,
		MODE_HEX1 = 7'b0001000,
		MODE_WBS  = 7'b0010000,
		MODE_WU   = 7'b0100000,
		MODE_HEX2 = 7'b1000000
	} mode_t;

	typedef enum logic [KindW-1:0] {
		KIND_CHAR = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [ErrW-1:0] {
		ERR_NONE         = 4'd0,
		ERR_NO_QUOTE     = 4'd1,
		ERR_CONTROL      = 4'd2,
		ERR_ESC_CUT      = 4'd3,
		ERR_BAD_ESC      = 4'd4,
		ERR_HEX_CUT      = 4'd5,
		ERR_BAD_HEX      = 4'd6,
		ERR_NO_LOW       = 4'd7,
		ERR_BAD_LOW      = 4'd8,
		ERR_LONE_LOW     = 4'd9,
		ERR_UNTERMINATED = 4'd10
	} err_t;

	localparam logic [CpW-1:0] CP_QUOTE  = 21'h22;
	localparam logic [CpW-1:0] CP_BSLASH = 21'h5C;
	localparam logic [CpW-1:0] CP_SLASH  = 21'h2F;
	localparam logic [CpW-1:0] CP_LOW_B  = 21'h62;
	localparam logic [CpW-1:0] CP_LOW_F  = 21'h66;
	localparam logic [CpW-1:0] CP_LOW_N  = 21'h6E;
	localparam logic [CpW-1:0] CP_LOW_R  = 21'h72;
	localparam logic [CpW-1:0] CP_LOW_T  = 21'h74;
	localparam logic [CpW-1:0] CP_LOW_U  = 21'h75;
	localparam logic [CpW-1:0] CP_SPACE  = 21'h20;
	localparam logic [CpW-1:0] CP_SUPP   = 21'h10000;

	// Parser state carried from one transaction to the next.
	typedef struct packed {
		mode_t       mode;
		logic [1:0]  digits;
		logic [15:0] acc;
		logic [9:0]  high;
	} pstate_t;

	// One result of a step.
	typedef struct packed {
		logic           emit;
		kind_t          kind;
		logic [CpW-1:0] ch;
		err_t           err;
	} presult_t;

	// Hex digit value in the low four bits; bit 4 is set for a non-digit.
	function automatic logic [4:0] hex_value(input logic [CpW-1:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 21'h30 && c <= 21'h39) v = {1'b0, c[3:0]};
		else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66))
			v = {1'b0, c[3:0] + 4'd9};
		return v;
	endfunction

endpackage

// ===== design/json_string_unescape_unit.sv =====
// Top level of the JSON string unescape unit: input register, parser state,
// and output register. Depends on jsu_pkg and jsu_step.
//
//   Channel  Direction  Handshake               Payload
//   s_*      in         s_tvalid / s_tready     s_tdata code point, s_tlast end of text
//   m_*      out        m_tvalid / m_tready     m_tdata char and error, m_tuser kind
//
// One transaction enters per cycle unless the output stalls. Each passes the input
// register, and its result, if any, then passes the output register.
// Throughput is one code point per clock while the output does not stall, set by the combinational parser step.
// A stalled output holds the input register once both registers are occupied,
// so s_tready then follows m_tready.
// Reset (arst_n low) empties both registers and returns the parser to idle.
module json_string_unescape_unit
	import jsu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [20:0] code_point, [23:21] zero
	input  logic                s_tlast,   // end_of_text
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [20:0] decoded_char, [24:21] error_code
	output logic [KindW-1:0]    m_tuser    // result_kind
);

	// Input register.
	logic           valid_s1;
	logic [CpW-1:0] cp_s1;
	logic           eot_s1;

	// Parser state.
	pstate_t st_q;
	pstate_t st_nxt;
	presult_t res;

	// Output register.
	logic           valid_s2;
	kind_t          kind_s2;
	logic [CpW-1:0] ch_s2;
	err_t           err_s2;

	logic out_free;
	logic advance;

	// The output register can take a new result when empty or being drained.
	assign out_free = !valid_s2 || m_tready;
	// The staged item is processed only when its result, if any, has room.
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cp_s1  <= s_tdata[CpW-1:0];
			eot_s1 <= s_tlast;
		end
	end

	jsu_step u_step (
		.cur (st_q),
		.cp  (cp_s1),
		.eot (eot_s1),
		.nxt (st_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_IDLE, digits: 2'd0, acc: 16'd0, high: 10'd0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			kind_s2 <= res.kind;
			ch_s2   <= res.ch;
			err_s2  <= res.err;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {{(OutDataW - CpW - ErrW){1'b0}}, err_s2, ch_s2};

endmodule

// ===== design/jsu_step.sv =====
// Next-state and result logic of the JSON string unescape unit for one
// code point or end-of-text mark. Purely combinational; depends on jsu_pkg.
module jsu_step
	import jsu_pkg::*;
(
	input  pstate_t        cur,
	input  logic [CpW-1:0] cp,
	input  logic           eot,
	output pstate_t        nxt,
	output presult_t       res
);

	localparam pstate_t StateIdle = '{mode: MODE_IDLE, digits: 2'd0, acc: 16'd0, high: 10'd0};

	logic [4:0]  hv;
	logic [15:0] val;

	assign hv  = hex_value(cp);
	assign val = {cur.acc[11:0], hv[3:0]};

	always_comb begin
		nxt = cur;
		res = '{emit: 1'b0, kind: KIND_CHAR, ch: '0, err: ERR_NONE};
		unique case (cur.mode)
			MODE_IDLE: begin
				if (!eot) begin
					if (cp == CP_QUOTE) nxt.mode = MODE_BODY;
					else begin
						res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_NO_QUOTE};
					end
				end
			end
			MODE_BODY: begin
				priority if (eot) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_UNTERMINATED};
				end else if (cp == CP_QUOTE) begin
					nxt.mode = MODE_IDLE;
					res = '{emit: 1'b1, kind: KIND_DONE, ch: '0, err: ERR_NONE};
				end else if (cp < CP_SPACE) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_CONTROL};
				end else if (cp == CP_BSLASH) begin
					nxt.mode = MODE_ESC;
				end else begin
					res = '{emit: 1'b1, kind: KIND_CHAR, ch: cp, err: ERR_NONE};
				end
			end
			MODE_ESC: begin
				if (eot) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_ESC_CUT};
				end else begin
					nxt.mode = MODE_BODY;
					res = '{emit: 1'b1, kind: KIND_CHAR, ch: '0, err: ERR_NONE};
					priority case (cp)
						CP_QUOTE, CP_BSLASH, CP_SLASH: res.ch = cp;
						CP_LOW_B: res.ch = 21'h08;
						CP_LOW_F: res.ch = 21'h0C;
						CP_LOW_N: res.ch = 21'h0A;
						CP_LOW_R: res.ch = 21'h0D;
						CP_LOW_T: res.ch = 21'h09;
						CP_LOW_U: begin
							nxt.mode   = MODE_HEX1;
							nxt.digits = 2'd0;
							nxt.acc    = 16'd0;
							res.emit   = 1'b0;
						end
						default: begin
							nxt = StateIdle;
							res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_BAD_ESC};
						end
					endcase
				end
			end
			MODE_HEX1, MODE_HEX2: begin
				priority if (eot) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_HEX_CUT};
				end else if (hv[4]) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_BAD_HEX};
				end else if (cur.digits != 2'd3) begin
					nxt.acc    = val;
					nxt.digits = cur.digits + 2'd1;
				end else if (cur.mode == MODE_HEX1) begin
					nxt.digits = 2'd0;
					nxt.acc    = 16'd0;
					priority if (val[15:10] == 6'b110110) begin
						nxt.high = val[9:0];
						nxt.mode = MODE_WBS;
					end else if (val[15:10] == 6'b110111) begin
						nxt = StateIdle;
						res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_LONE_LOW};
					end else begin
						nxt.mode = MODE_BODY;
						res = '{emit: 1'b1, kind: KIND_CHAR, ch: {5'd0, val}, err: ERR_NONE};
					end
				end else begin
					if (val[15:10] != 6'b110111) begin
						nxt = StateIdle;
						res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_BAD_LOW};
					end else begin
						nxt = '{mode: MODE_BODY, digits: 2'd0, acc: 16'd0, high: 10'd0};
						res = '{emit: 1'b1, kind: KIND_CHAR,
							ch: CP_SUPP + {1'b0, cur.high, val[9:0]}, err: ERR_NONE};
					end
				end
			end
			MODE_WBS: begin
				if (eot || cp != CP_BSLASH) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_NO_LOW};
				end else nxt.mode = MODE_WU;
			end
			MODE_WU: begin
				if (eot || cp != CP_LOW_U) begin
					nxt = StateIdle;
					res = '{emit: 1'b1, kind: KIND_ERR, ch: '0, err: ERR_NO_LOW};
				end else begin
					nxt.mode   = MODE_HEX2;
					nxt.digits = 2'd0;
					nxt.acc    = 16'd0;
				end
			end
			default: nxt = StateIdle;
		endcase
	end

endmodule

// ===== design/jsu_checker.sv =====
// Port-level checker for json_string_unescape_unit, with its bind statement.
// Depends on jsu_pkg.
module jsu_checker
	import jsu_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic [KindW-1:0]    m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_CHAR |-> m_tdata[24:21] == ERR_NONE)
		else $error("character result carries an error code");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERR |->
			m_tdata[20:0] == '0 && m_tdata[24:21] != ERR_NONE
			&& m_tdata[24:21] <= ERR_UNTERMINATED)
		else $error("malformed error result");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DONE |-> m_tdata[24:0] == '0)
		else $error("close result carries payload");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
